[hdl/nsc_pkg.sv]
// nsc_pkg: shared types and codes for the natural string compare block
// no dependencies; imported by the channel interfaces, the top level and the checker
`default_nettype none

package nsc_pkg;

    typedef logic [7:0] byte_t;
    typedef logic signed [1:0] order_t;

    localparam order_t ORDER_LESS    = 2'sb11;
    localparam order_t ORDER_EQUAL   = 2'sb00;
    localparam order_t ORDER_GREATER = 2'sb01;

    localparam byte_t NUL_BYTE   = 8'h00;
    localparam byte_t DIGIT_LOW  = 8'h30;
    localparam byte_t DIGIT_HIGH = 8'h39;

    function automatic logic is_digit(input byte_t c);
        return (c >= DIGIT_LOW) && (c <= DIGIT_HIGH);
    endfunction

    function automatic order_t byte_order(input byte_t a, input byte_t b);
        order_t r;
        if (a > b)
        begin
            r = ORDER_GREATER;
        end
        else if (a < b)
        begin
            r = ORDER_LESS;
        end
        else
        begin
            r = ORDER_EQUAL;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/nsc_if.sv]
// nsc_pair_if and nsc_order_if: valid/ready channels of the compare block
// depends on nsc_pkg for the payload types
`default_nettype none

interface nsc_pair_if;
    logic            valid;
    logic            ready;
    nsc_pkg::byte_t  char_a;
    nsc_pkg::byte_t  char_b;
    logic            first_pair;

    modport source (output valid, output char_a, output char_b, output first_pair,
                    input ready);
    modport sink   (input valid, input char_a, input char_b, input first_pair,
                    output ready);
endinterface

interface nsc_order_if;
    logic            valid;
    logic            ready;
    nsc_pkg::order_t order;

    modport source (output valid, output order, input ready);
    modport sink   (input valid, input order, output ready);
endinterface

`default_nettype wire

[hdl/natural_string_compare.sv]
// natural_string_compare: streaming natural-order compare of two byte strings
// depends on nsc_pkg and the channel interfaces in nsc_if.sv
//
// usage
//   pairs  : one word per byte position, char_a and char_b in lockstep; 0 ends a string.
//            first_pair starts a new comparison and clears the run state.
//   result : one word per comparison, order = -1 / 0 / +1, given at the pair that
//            decides it; pairs after that are swallowed until the next first_pair.
// timing
//   a word is taken every cycle while pairs.ready is high; an input register feeds one level of
//   compare logic which loads the result register, so a deciding pair passes the input register
//   and then the result register before it shows on result. pairs that decide nothing
//   leave no trace but the updated run state.
// stalls
//   while result is held by the receiver, pairs that decide nothing still drain
//   through; only a deciding pair waits in the input register, and pairs.ready
//   drops behind it.
// reset
//   rst_n clears both registers' valid flags and sets the block to "decided",
//   so every pair is ignored until a word with first_pair arrives.
`default_nettype none

module natural_string_compare
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    nsc_pair_if.sink   pairs,
    nsc_order_if.source result
);
    import nsc_pkg::*;

    // input register
    logic   in_valid_reg;
    byte_t  a_reg;
    byte_t  b_reg;
    logic   first_reg;

    // comparison state
    logic   in_run_reg,  in_run_next;
    order_t diff_reg,    diff_next;
    logic   decided_reg, decided_next;

    // result register
    logic   out_valid_reg;
    order_t order_reg, order_next;

    logic   emit;       // pair in the input register decides the comparison
    logic   advance;    // input register item leaves this cycle
    logic   pair_fire;

    // decision logic on the registered pair
    always_comb
    begin
        logic   run_w;
        order_t diff_w;
        logic   dec_w;
        logic   ad;
        logic   bd;
        logic   plain;

        run_w  = first_reg ? 1'b0 : in_run_reg;
        diff_w = first_reg ? ORDER_EQUAL : diff_reg;
        dec_w  = first_reg ? 1'b0 : decided_reg;
        ad     = is_digit(a_reg);
        bd     = is_digit(b_reg);
        plain  = 1'b0;

        in_run_next  = run_w;
        diff_next    = diff_w;
        decided_next = dec_w;
        emit         = 1'b0;
        order_next   = ORDER_EQUAL;

        if (!dec_w)
        begin
            if (run_w)
            begin
                if (ad && bd)
                begin
                    if (diff_w == ORDER_EQUAL)
                    begin
                        diff_next = byte_order(a_reg, b_reg);
                    end
                end
                else if (ad)
                begin
                    emit       = 1'b1;
                    order_next = ORDER_GREATER;
                end
                else if (bd)
                begin
                    emit       = 1'b1;
                    order_next = ORDER_LESS;
                end
                else if (diff_w != ORDER_EQUAL)
                begin
                    emit       = 1'b1;
                    order_next = diff_w;
                end
                else
                begin
                    // equal runs: the ending pair is compared as plain text
                    in_run_next = 1'b0;
                    plain       = 1'b1;
                end
            end
            else
            begin
                plain = 1'b1;
            end

            if (plain)
            begin
                if (a_reg == NUL_BYTE && b_reg == NUL_BYTE)
                begin
                    emit       = 1'b1;
                    order_next = ORDER_EQUAL;
                end
                else if (a_reg == NUL_BYTE)
                begin
                    emit       = 1'b1;
                    order_next = ORDER_LESS;
                end
                else if (b_reg == NUL_BYTE)
                begin
                    emit       = 1'b1;
                    order_next = ORDER_GREATER;
                end
                else if (ad && bd)
                begin
                    in_run_next = 1'b1;
                    diff_next   = byte_order(a_reg, b_reg);
                end
                else if (ad)
                begin
                    emit       = 1'b1;
                    order_next = ORDER_LESS;
                end
                else if (bd)
                begin
                    emit       = 1'b1;
                    order_next = ORDER_GREATER;
                end
                else if (byte_order(a_reg, b_reg) != ORDER_EQUAL)
                begin
                    emit       = 1'b1;
                    order_next = byte_order(a_reg, b_reg);
                end
            end

            if (emit)
            begin
                decided_next = 1'b1;
            end
        end
    end

    // a deciding pair needs a free result slot; anything else passes
    assign advance     = in_valid_reg && (!emit || !out_valid_reg || result.ready);
    assign pairs.ready = !in_valid_reg || advance;
    assign pair_fire   = pairs.valid && pairs.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_run_reg    <= 1'b0;
            diff_reg      <= ORDER_EQUAL;
            decided_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pairs.ready)
            begin
                in_valid_reg <= pairs.valid;
            end
            if (advance)
            begin
                in_run_reg  <= in_run_next;
                diff_reg    <= diff_next;
                decided_reg <= decided_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pair_fire)
        begin
            a_reg     <= pairs.char_a;
            b_reg     <= pairs.char_b;
            first_reg <= pairs.first_pair;
        end
        if (advance && emit)
        begin
            order_reg <= order_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.order = order_reg;

endmodule

`default_nettype wire

[hdl/nsc_checker.sv]
// nsc_port_checks: port-level checks on natural_string_compare, bound to the top level
// depends on nsc_pkg and natural_string_compare
`default_nettype none

module nsc_port_checks
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire nsc_pkg::order_t out_order
);
    import nsc_pkg::*;

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_order))
        else $error("result changed while stalled");

    // only the three defined codes appear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_order == ORDER_LESS || out_order == ORDER_EQUAL
                       || out_order == ORDER_GREATER))
        else $error("undefined order code");

    // a fresh result comes from a pair taken earlier through the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_fire, 2))
        else $error("result without a preceding pair");

endmodule

bind natural_string_compare nsc_port_checks u_port_checks
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pairs.valid),
    .in_ready  (pairs.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_order (result.order)
);

`default_nettype wire

[tb/nsc_checker.sv]
// nsc_checker: watches the pair and result channels of natural_string_compare,
// predicts the order of every comparison and checks each result word against it
// depends on nsc_pkg and the channel interfaces in nsc_if.sv
`default_nettype none

module nsc_checker
(
    input  wire logic clk,
    input  wire logic rst_n,
    nsc_pair_if       pairs,
    nsc_order_if      result,
    output int        errors,
    output int        pending,
    output int        live_pairs,
    output int        orders_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import nsc_pkg::*;

    order_t due_orders[$];

    // mirror of the compare state
    logic   run_open;
    order_t run_diff;
    logic   settled;

    int mismatch_count;
    int live_count;
    int checked_count;

    function automatic logic numeral(input byte_t c);
        return c inside {[DIGIT_LOW:DIGIT_HIGH]};
    endfunction

    function automatic order_t rank(input byte_t a, input byte_t b);
        int d;
        d = int'(a) - int'(b);
        return (d > 0) ? ORDER_GREATER : (d < 0) ? ORDER_LESS : ORDER_EQUAL;
    endfunction

    // advance the mirror by one word; live is low when the word is swallowed
    function automatic void order_of_pair(input byte_t a, input byte_t b, input logic first,
                                          output logic live, output logic emits,
                                          output order_t verdict);
        logic da;
        logic db;
        emits   = 1'b0;
        verdict = ORDER_EQUAL;
        if (first)
        begin
            run_open = 1'b0;
            run_diff = ORDER_EQUAL;
            settled  = 1'b0;
        end
        live = !settled;
        if (settled)
        begin
            return;
        end
        da = numeral(a);
        db = numeral(b);
        if (run_open)
        begin
            if (da && db)
            begin
                if (run_diff == ORDER_EQUAL)
                begin
                    run_diff = rank(a, b);
                end
                return;
            end
            if (da)
            begin
                emits   = 1'b1;
                verdict = ORDER_GREATER;
            end
            else if (db)
            begin
                emits   = 1'b1;
                verdict = ORDER_LESS;
            end
            else if (run_diff != ORDER_EQUAL)
            begin
                emits   = 1'b1;
                verdict = run_diff;
            end
            else
            begin
                run_open = 1'b0;
            end
            if (emits)
            begin
                settled = 1'b1;
                return;
            end
        end
        if (a == NUL_BYTE || b == NUL_BYTE)
        begin
            emits   = 1'b1;
            verdict = (a == b) ? ORDER_EQUAL : (a == NUL_BYTE) ? ORDER_LESS : ORDER_GREATER;
        end
        else if (da && db)
        begin
            run_open = 1'b1;
            run_diff = rank(a, b);
        end
        else if (da || db)
        begin
            emits   = 1'b1;
            verdict = da ? ORDER_LESS : ORDER_GREATER;
        end
        else if (rank(a, b) != ORDER_EQUAL)
        begin
            emits   = 1'b1;
            verdict = rank(a, b);
        end
        if (emits)
        begin
            settled = 1'b1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic   live;
        logic   emits;
        order_t verdict;
        order_t want;
        if (!rst_n)
        begin
            due_orders.delete();
            run_open       = 1'b0;
            run_diff       = ORDER_EQUAL;
            settled        = 1'b1;
            mismatch_count = 0;
            live_count     = 0;
            checked_count  = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (due_orders.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected order word, expected none got %0d",
                             $time, result.order);
                end
                else
                begin
                    want = due_orders.pop_front();
                    checked_count++;
                    if (result.order !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: order mismatch, expected %0d got %0d",
                                 $time, want, result.order);
                    end
                end
            end
            if (pairs.valid && pairs.ready)
            begin
                order_of_pair(pairs.char_a, pairs.char_b, pairs.first_pair,
                              live, emits, verdict);
                if (live)
                begin
                    live_count++;
                end
                if (emits)
                begin
                    due_orders.push_back(verdict);
                end
            end
        end
        errors         <= mismatch_count;
        pending        <= due_orders.size();
        live_pairs     <= live_count;
        orders_checked <= checked_count;
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench: stimulus and verdict for natural_string_compare
// drives byte pairs and result back-pressure; prediction and checking sit in nsc_checker
// depends on nsc_pkg, nsc_if.sv, nsc_checker.sv and the block itself
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import nsc_pkg::*;

    // stop once the block has taken this many words, swallowed ones included
    localparam int PAIR_GOAL      = 1250;
    // watchdog limit in cycles for the whole run
    localparam int CYCLE_LIMIT    = 500000;
    // long receiver hold-off, enough to fill both block registers and stall pairs
    localparam int HOLD_CYCLES    = 400;
    // a result shows after its pair passes the input and result registers; settle before the verdict
    localparam int SETTLE_CYCLES  = 8;

    logic clk;
    logic rst_n;

    nsc_pair_if  pairs();
    nsc_order_if result();

    int errors;
    int pending;
    int live_pairs;
    int orders_checked;

    int   cycle_count;
    int   compares_started;
    int   pairs_sent;
    int   burst_left;
    logic hold_req = 1'b0;

    // strings under construction, one byte per entry, no terminator stored
    byte_t scratch[$];
    byte_t str_a[$];
    byte_t str_b[$];

    natural_string_compare u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pairs  (pairs),
        .result (result)
    );

    nsc_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .pairs          (pairs),
        .result         (result),
        .errors         (errors),
        .pending        (pending),
        .live_pairs     (live_pairs),
        .orders_checked (orders_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d orders still due", cycle_count, pending);
        $display("status: fail");
        $finish;
    end

    // receiver: moves between always-ready, mostly-ready, mostly-stalled and
    // periodic stretches; a hold request forces a long stall on top of that
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase = (phase + 1) % 5;
                case (mode)
                    0:       result.ready <= 1'b1;
                    1:       result.ready <= ($urandom_range(0, 3) != 0);
                    2:       result.ready <= ($urandom_range(0, 3) == 0);
                    default: result.ready <= (phase == 0);
                endcase
            end
        end
    end

    // offer one word and hold it until taken; bursts of random length with
    // random gaps in between, a quarter of the bursts follow on with no gap
    task automatic send_pair(input byte_t a, input byte_t b, input logic first);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                pairs.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        if (first)
        begin
            compares_started++;
        end
        pairs.valid      <= 1'b1;
        pairs.char_a     <= a;
        pairs.char_b     <= b;
        pairs.first_pair <= first;
        @(posedge clk);
        while (!pairs.ready)
        begin
            @(posedge clk);
        end
        pairs_sent++;
    endtask

    // stop offering and wait until every predicted order word is back
    task automatic drain_orders();
        pairs.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    // a few tokens of digit runs, letters and odd bytes (never NUL)
    task automatic build_string();
        int tokens;
        int n;
        scratch.delete();
        tokens = $urandom_range(0, 4);
        repeat (tokens)
        begin
            case ($urandom_range(0, 5))
                0, 1, 2:
                begin
                    // digit run, sometimes with leading zeros
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
                    if ($urandom_range(0, 4) == 0)
                    begin
                        scratch.push_back(DIGIT_LOW);
                    end
                    repeat (n) scratch.push_back(byte_t'(DIGIT_LOW + $urandom_range(0, 9)));
                end
                3, 4:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) scratch.push_back(byte_t'("a" + $urandom_range(0, 25)));
                end
                default:
                begin
                    scratch.push_back(byte_t'($urandom_range(1, 255)));
                end
            endcase
        end
    endtask

    // second string mostly a near copy of the first so the compare runs deep
    task automatic build_pair_of_strings();
        int pos;
        build_string();
        str_a = scratch;
        str_b = str_a;
        pos   = $urandom_range(0, str_a.size());
        case ($urandom_range(0, 7))
            0: ;  // identical strings
            1, 2:
            begin
                if (pos < str_b.size())
                begin
                    str_b[pos] = byte_t'(DIGIT_LOW + $urandom_range(0, 9));
                end
            end
            3: str_b.insert(pos, byte_t'(DIGIT_LOW + $urandom_range(0, 9)));
            4:
            begin
                if (pos < str_b.size())
                begin
                    str_b.delete(pos);
                end
            end
            5:
            begin
                while (str_b.size() > pos)
                begin
                    void'(str_b.pop_back());
                end
            end
            6:
            begin
                if (pos < str_b.size())
                begin
                    str_b[pos] = byte_t'($urandom_range(1, 255));
                end
            end
            default:
            begin
                build_string();
                str_b = scratch;
            end
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            scratch = str_a;
            str_a   = str_b;
            str_b   = scratch;
        end
    endtask

    // stream both strings in lockstep; past its terminator a string carries
    // junk, which the block must swallow once decided; now and then the stream
    // is cut short so the next first word aborts an open comparison
    task automatic send_strings();
        int    len;
        int    cut;
        byte_t a;
        byte_t b;
        len = ((str_a.size() > str_b.size()) ? str_a.size() : str_b.size()) + 1;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
        for (int i = 0; i < cut; i++)
        begin
            a = (i < str_a.size()) ? str_a[i] :
                (i == str_a.size()) ? NUL_BYTE : byte_t'($urandom_range(0, 255));
            b = (i < str_b.size()) ? str_b[i] :
                (i == str_b.size()) ? NUL_BYTE : byte_t'($urandom_range(0, 255));
            send_pair(a, b, i == 0);
        end
        repeat ($urandom_range(0, 2))
        begin
            send_pair(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial
    begin
        logic hold_done;
        logic drain_done;
        hold_done        = 1'b0;
        drain_done       = 1'b0;
        burst_left       = 0;
        compares_started = 0;
        pairs_sent       = 0;
        rst_n            <= 1'b0;
        pairs.valid      <= 1'b0;
        pairs.char_a     <= NUL_BYTE;
        pairs.char_b     <= NUL_BYTE;
        pairs.first_pair <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // --- directed part ---
        // words before any first word are swallowed
        send_pair("A", "B", 1'b0);
        send_pair(NUL_BYTE, NUL_BYTE, 1'b0);
        // both strings empty, then one side empty
        send_pair(NUL_BYTE, NUL_BYTE, 1'b1);
        send_pair(NUL_BYTE, "a", 1'b1);
        send_pair("a", NUL_BYTE, 1'b1);
        // word after a decision is swallowed
        send_pair("q", "q", 1'b0);
        // digit sorts before non-digit, both ways
        send_pair("5", "A", 1'b1);
        send_pair("z", "0", 1'b1);
        // high bytes are plain text, and the bytes just outside the digit range
        send_pair(8'hFF, 8'h80, 1'b1);
        send_pair(8'h2F, 8'h3A, 1'b1);
        send_pair(8'h80, 8'h80, 1'b1);
        send_pair(8'h7F, 8'h7F, 1'b0);
        send_pair(NUL_BYTE, NUL_BYTE, 1'b0);
        // "12" vs "9": longer run wins although its first digit is smaller
        send_pair("1", "9", 1'b1);
        send_pair("2", NUL_BYTE, 1'b0);
        // "19" vs "25": equal lengths, first differing digit decides at run end
        send_pair("1", "2", 1'b1);
        send_pair("9", "5", 1'b0);
        send_pair(NUL_BYTE, NUL_BYTE, 1'b0);
        // "07x" vs "07x": equal runs fall back to text, then equal end
        send_pair("0", "0", 1'b1);
        send_pair("7", "7", 1'b0);
        send_pair("x", "x", 1'b0);
        send_pair(NUL_BYTE, NUL_BYTE, 1'b0);
        // "3a" vs "3b": run ends on a text pair that decides
        send_pair("3", "3", 1'b1);
        send_pair("a", "b", 1'b0);

        // --- random part ---
        while (pairs_sent < PAIR_GOAL)
        begin
            if (!hold_done && pairs_sent >= 300)
            begin
                // receiver stalls long while words keep coming
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && pairs_sent >= 700)
            begin
                drain_orders();
                drain_done = 1'b1;
            end
            if ($urandom_range(0, 6) == 0)
            begin
                // noise: raw bytes, first flag set at random (restarts mid-compare)
                repeat ($urandom_range(1, 6))
                begin
                    send_pair(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
                              $urandom_range(0, 3) == 0);
                end
            end
            else
            begin
                build_pair_of_strings();
                send_strings();
            end
        end

        drain_orders();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d comparisons over %0d byte pairs (%0d live), %0d order words checked",
                 compares_started, pairs_sent, live_pairs, orders_checked);
        $display("with directed edge bytes, natural strings, noise, a long stall and a drain");
        if (errors == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches, %0d order words never arrived", errors, pending);
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
